>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk with reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold, disabled during reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// Mipmap box downsampler package
// Shared types and constants of the mipmap downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int unsigned CfgWidth = 13;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned LevelCountWidth = 4;
  localparam int unsigned ChanWidth = 8;
  localparam int unsigned PairWidth = 9;
  localparam int unsigned PixelWidth = 4 * ChanWidth;
  localparam int unsigned SumWidth = 4 * PairWidth;
  localparam int unsigned OutDataWidth = 64;

  localparam logic [CfgIndexWidth-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_LEVEL_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_AVG
  } state_t;

endpackage

>>> hw/rtl/mipmap_box_downsampler.sv
// ----------------------------------------------------------------------------
// Mipmap box downsampler
// Passes RGBA8 base pixels through and builds every lower mip level by
// 2x2 box averaging, one level of the cascade per step.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    request    base pixel, tdata red, green, blue, alpha from bit 0 up
// m_axis    result     level, column, row, pixel, tlast on the final result
// cfg       write      image_width, image_height, level_count
//
// A request is accepted in ST_IDLE and each result level is emitted from
// ST_EMIT, plus an ST_AVG step per level averaged from the row sum memory.
// The row sum memory is a synchronous RAM with a registered read.
// Reset and an image_width, image_height or level_count write return every
// level to column 0, row 0. A stalled result holds the cascade until taken.
// ----------------------------------------------------------------------------
module mipmap_box_downsampler #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_LEVELS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red_in, green_in, blue_in, alpha_in
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // level, column, row, red, green, blue, alpha, zero fill
  output logic [mbd_pkg::OutDataWidth-1:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_write,
  input  logic [mbd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [mbd_pkg::CfgWidth-1:0]      cfg_data
);

`include "assert_macros.svh"

  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned AW = CW;

  mbd_pkg::state_t state, state_next;

  logic [mbd_pkg::CfgWidth-1:0] image_width, image_height;
  logic [mbd_pkg::LevelCountWidth-1:0] level_count;

  logic [CW-1:0] pos_col [MAX_LEVELS];
  logic [RW-1:0] pos_row [MAX_LEVELS];
  logic [mbd_pkg::PixelWidth-1:0] left_pixel [MAX_LEVELS];
  logic [mbd_pkg::SumWidth-1:0] row_pair_sums [MAX_WIDTH];

  logic [LW-1:0] lv;
  logic [mbd_pkg::LevelCountWidth-1:0] n_lv;
  logic [WW-1:0] cur_w;
  logic [HW-1:0] cur_h;
  logic [AW-1:0] base;
  logic [mbd_pkg::PixelWidth-1:0] px;
  logic [mbd_pkg::SumWidth-1:0] hsum;
  logic [mbd_pkg::SumWidth-1:0] rd_data;

  logic s_fire, fire, go, left_we, mem_we, mem_re, last_lvl;
  logic [CW-1:0] col, ncol;
  logic [RW-1:0] row, nrow;
  logic [WW-1:0] wn;
  logic [HW-1:0] hn;
  logic [AW-1:0] idx;
  logic [mbd_pkg::SumWidth-1:0] hsum_c;
  logic [mbd_pkg::PixelWidth-1:0] avg_c;
  logic [WW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;
  logic [mbd_pkg::LevelCountWidth-1:0] n_clamp;
  logic [31:0] col32, row32;

  always_comb begin
    if (image_width == '0) begin
      w_clamp = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(image_width);
    end
    if (image_height == '0) begin
      h_clamp = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(image_height);
    end
    if (level_count == '0) begin
      n_clamp = 4'd1;
    end else if (32'(level_count) > MAX_LEVELS) begin
      n_clamp = 4'(MAX_LEVELS);
    end else begin
      n_clamp = level_count;
    end
  end

  always_comb begin
    col = pos_col[lv];
    row = pos_row[lv];
    wn = cur_w >> 1;
    hn = cur_h >> 1;
    ncol = col + CW'(1);
    nrow = row;
    if (32'(col) + 32'd1 >= 32'(cur_w)) begin
      ncol = '0;
      nrow = row + RW'(1);
      if (32'(row) + 32'd1 >= 32'(cur_h)) begin
        nrow = '0;
      end
    end
    last_lvl = (32'(lv) + 32'd1 >= 32'(n_lv));
    go = !last_lvl && (wn != '0) && (hn != '0) &&
         (32'(col) < (32'(wn) << 1)) && (32'(row) < (32'(hn) << 1));
    for (int c = 0; c < 4; c++) begin
      hsum_c[c*mbd_pkg::PairWidth +: mbd_pkg::PairWidth] =
        9'(left_pixel[lv][c*mbd_pkg::ChanWidth +: mbd_pkg::ChanWidth]) +
        9'(px[c*mbd_pkg::ChanWidth +: mbd_pkg::ChanWidth]);
    end
    for (int c = 0; c < 4; c++) begin
      logic [9:0] t;
      t = 10'(rd_data[c*mbd_pkg::PairWidth +: mbd_pkg::PairWidth]) +
          10'(hsum[c*mbd_pkg::PairWidth +: mbd_pkg::PairWidth]);
      avg_c[c*mbd_pkg::ChanWidth +: mbd_pkg::ChanWidth] = t[9:2];
    end
    idx = AW'(32'(base) + 32'(col >> 1));
    col32 = 32'(col);
    row32 = 32'(row);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mbd_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_next = mbd_pkg::ST_EMIT;
        end
      end
      mbd_pkg::ST_EMIT: begin
        if (fire) begin
          state_next = mem_re ? mbd_pkg::ST_AVG : mbd_pkg::ST_IDLE;
        end
      end
      mbd_pkg::ST_AVG: begin
        state_next = mbd_pkg::ST_EMIT;
      end
      default: begin
        state_next = mbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (state == mbd_pkg::ST_IDLE);
    s_fire = s_axis_tvalid && s_axis_tready;
    fire = (state == mbd_pkg::ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
    left_we = fire && go && !col[0];
    mem_we = fire && go && col[0] && !row[0];
    mem_re = fire && go && col[0] && row[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbd_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
      image_width <= 13'd4096;
      image_height <= 13'd4096;
      level_count <= 4'd13;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        pos_col[i] <= '0;
        pos_row[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (fire) begin
        m_axis_tvalid <= 1'b1;
        pos_col[lv] <= ncol;
        pos_row[lv] <= nrow;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          mbd_pkg::REG_IMAGE_WIDTH:  image_width <= cfg_data;
          mbd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          mbd_pkg::REG_LEVEL_COUNT:  level_count <= cfg_data[3:0];
          default: ;
        endcase
        if (cfg_index == mbd_pkg::REG_IMAGE_WIDTH ||
            cfg_index == mbd_pkg::REG_IMAGE_HEIGHT ||
            cfg_index == mbd_pkg::REG_LEVEL_COUNT) begin
          for (int i = 0; i < MAX_LEVELS; i++) begin
            pos_col[i] <= '0;
            pos_row[i] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      px <= s_axis_tdata;
      lv <= '0;
      base <= '0;
      cur_w <= w_clamp;
      cur_h <= h_clamp;
      n_lv <= n_clamp;
    end
    if (fire) begin
      m_axis_tdata <= {4'd0, px, row32[11:0], col32[11:0], 4'(lv)};
      m_axis_tlast <= !mem_re;
      hsum <= hsum_c;
    end
    if (left_we) begin
      left_pixel[lv] <= px;
    end
    if (state == mbd_pkg::ST_AVG) begin
      px <= avg_c;
      lv <= lv + LW'(1);
      base <= base + AW'(wn);
      cur_w <= wn;
      cur_h <= hn;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_pair_sums[idx] <= hsum_c;
    end
    if (mem_re) begin
      rd_data <= row_pair_sums[idx];
    end
  end

  `ASSERT_NEVER(a_mem_rw, clk, rst, mem_we && mem_re, "row sum read and write collide")
  `ASSERT_CLK(a_avg_from_emit, clk, rst, (state == mbd_pkg::ST_AVG) |-> ($past(mem_re)), "average without read")
  `ASSERT_CLK(a_accept_emit, clk, rst, s_fire |=> (state == mbd_pkg::ST_EMIT), "request not emitted")

endmodule
